// ===== hw/rtl/lrt_pkg.sv =====
package lrt_pkg;

  // Widths of the interface fields
  localparam int unsigned SampleW = 10;
  localparam int unsigned FieldW  = 24;
  localparam int unsigned DistW   = 12;
  localparam int unsigned KW      = 11;

  // Widest tick counter the design supports
  localparam int unsigned TimeMax = 32;

  localparam int unsigned TimeBitsDef  = 24;
  localparam int unsigned FifoDepthDef = 4;

  localparam logic [KW-1:0]    KCm     = 11'd1833;
  localparam logic [KW-1:0]    KIn     = 11'd722;
  localparam logic [DistW-1:0] DistMax = 12'd4095;

  localparam logic [SampleW-1:0] EchoThrRst     = 10'd512;
  localparam logic [SampleW-1:0] ZeroThrRst     = 10'd512;
  localparam logic [FieldW-1:0]  SyncTimeoutRst = 24'd30000;
  localparam logic               UnitSelRst     = 1'b0;

  typedef enum logic [1:0] {
    CfgEchoThr     = 2'd0,
    CfgZeroThr     = 2'd1,
    CfgSyncTimeout = 2'd2,
    CfgUnitSel     = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    StDistOk      = 2'd0,
    StNoEcho      = 2'd1,
    StSyncTimeout = 2'd2,
    StCalDone     = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    PhCalHigh = 4'd0,
    PhCalLow  = 4'd1,
    PhCalMeas = 4'd2,
    PhZrHigh  = 4'd3,
    PhZrLow   = 4'd4,
    PhZrWait  = 4'd5,
    PhMHigh   = 4'd6,
    PhMLow    = 4'd7,
    PhMEcho   = 4'd8,
    PhMPeak   = 4'd9
  } phase_e;

  typedef enum logic [2:0] {
    BkIdle = 3'd0,
    BkMul  = 3'd1,
    BkChk  = 3'd2,
    BkDiv  = 3'd3,
    BkOut  = 3'd4
  } back_e;

  typedef struct packed {
    logic               sync_level;
    logic [SampleW-1:0] echo_sample;
    logic [SampleW-1:0] zero_sample;
  } tick_t;

  typedef struct packed {
    status_e            status;
    logic [DistW-1:0]   distance;
    logic [FieldW-1:0]  echo_width;
    logic [SampleW-1:0] echo_peak;
    logic [FieldW-1:0]  sync_period;
  } result_t;

  // One finished measurement handed from the timing front to the back end
  typedef struct packed {
    status_e            status;
    logic               dist_ok;
    logic               inch;
    logic [TimeMax-1:0] delta;
    logic [TimeMax-1:0] divisor;
    logic [FieldW-1:0]  echo_width;
    logic [SampleW-1:0] echo_peak;
    logic [FieldW-1:0]  sync_period;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// ===== hw/rtl/lrt_front.sv =====
module lrt_front
  import lrt_pkg::*;
#(
  parameter int unsigned TIME_BITS = TimeBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  tick_t              tick_i,
  input  logic [SampleW-1:0] echo_thr_i,
  input  logic [SampleW-1:0] zero_thr_i,
  input  logic [FieldW-1:0]  sync_timeout_i,
  input  logic               unit_sel_i,
  output logic               push_o,
  output job_t               job_o
);

  localparam logic [TIME_BITS-1:0] TSat = '1;

  phase_e               phase_q, phase_d;
  logic [TIME_BITS-1:0] tick_q, tick_d;
  logic [TIME_BITS-1:0] msw_q, msw_d;
  logic [TIME_BITS-1:0] zdly_q, zdly_d;
  logic [TIME_BITS-1:0] edly_q, edly_d;
  logic [SampleW-1:0]   peak_q, peak_d;
  logic [TIME_BITS-1:0] pulse_q, pulse_d;

  logic [TIME_BITS-1:0] tick_inc, pulse_inc;
  logic [TIME_BITS:0]   width2;
  logic [TimeMax:0]     tick_ext, tmo_ext;
  logic [TimeMax-1:0]   msw_w, pulse_w, delta_w;
  logic                 sync, sync_to, echo_to, echo_hit, zero_hit, peak_fall;

  assign tick_inc  = (tick_q == TSat) ? tick_q : tick_q + 1'b1;
  assign pulse_inc = (pulse_q == TSat) ? pulse_q : pulse_q + 1'b1;
  assign width2    = {tick_inc, 1'b0};
  assign tick_ext  = (TimeMax + 1)'(tick_inc);
  assign tmo_ext   = (TimeMax + 1)'(sync_timeout_i);

  assign sync      = tick_i.sync_level;
  assign sync_to   = tick_ext > tmo_ext;
  assign echo_to   = (TIME_BITS + 1)'(tick_inc) > {msw_q, 1'b0};
  assign echo_hit  = tick_i.echo_sample >= echo_thr_i;
  assign zero_hit  = tick_i.zero_sample >= zero_thr_i;
  assign peak_fall = tick_i.echo_sample < peak_q;

  assign msw_w   = TimeMax'(msw_q);
  assign pulse_w = TimeMax'(pulse_inc);
  assign delta_w = TimeMax'(edly_q - zdly_q);

  always_comb begin
    phase_d = phase_q;
    if (step_i) begin
      case (phase_q)
        PhCalHigh: if (sync) phase_d = PhCalLow;
        PhCalLow:  if (!sync) phase_d = PhCalMeas;
        PhCalMeas: if (sync) phase_d = PhZrHigh;
        PhZrHigh:  if (sync) phase_d = PhZrLow;
        PhMHigh:   if (sync) phase_d = PhMLow;
        PhZrLow: begin
          if (sync_to) phase_d = PhMHigh;
          else if (!sync) phase_d = PhZrWait;
        end
        PhMLow: begin
          if (sync_to) phase_d = PhMHigh;
          else if (!sync) phase_d = PhMEcho;
        end
        PhZrWait: if (zero_hit) phase_d = PhMHigh;
        PhMEcho: begin
          if (echo_hit) phase_d = PhMPeak;
          else if (echo_to) phase_d = PhMHigh;
        end
        PhMPeak: if (peak_fall) phase_d = PhMHigh;
        default: phase_d = PhCalHigh;
      endcase
    end
  end

  always_comb begin
    tick_d  = tick_q;
    msw_d   = msw_q;
    zdly_d  = zdly_q;
    edly_d  = edly_q;
    peak_d  = peak_q;
    pulse_d = pulse_q;
    push_o  = 1'b0;
    job_o             = '0;
    job_o.status      = StDistOk;
    job_o.sync_period = msw_w[FieldW-1:0];
    if (step_i) begin
      case (phase_q)
        PhCalHigh: ;
        PhCalLow: if (!sync) tick_d = '0;
        PhCalMeas: begin
          tick_d = tick_inc;
          if (sync) begin
            // sync width is twice the low phase
            msw_d  = width2[TIME_BITS] ? TSat : width2[TIME_BITS-1:0];
            tick_d = '0;
          end
        end
        PhZrHigh, PhMHigh: tick_d = tick_inc;
        PhZrLow, PhMLow: begin
          tick_d = tick_inc;
          if (sync_to) begin
            tick_d = '0;
            push_o = 1'b1;
            if (phase_q == PhZrLow) begin
              zdly_d       = '0;
              job_o.status = StCalDone;
            end else begin
              job_o.status = StSyncTimeout;
            end
          end else if (!sync) begin
            tick_d = '0;
          end
        end
        PhZrWait: begin
          tick_d = tick_inc;
          if (zero_hit) begin
            zdly_d       = tick_inc;
            tick_d       = '0;
            push_o       = 1'b1;
            job_o.status = StCalDone;
          end
        end
        PhMEcho: begin
          tick_d = tick_inc;
          if (echo_hit) begin
            edly_d  = tick_inc;
            peak_d  = tick_i.echo_sample;
            pulse_d = '0;
          end else if (echo_to) begin
            tick_d       = '0;
            push_o       = 1'b1;
            job_o.status = StNoEcho;
          end
        end
        PhMPeak: begin
          pulse_d = pulse_inc;
          if (!peak_fall) begin
            peak_d = tick_i.echo_sample;
          end else begin
            tick_d           = '0;
            push_o           = 1'b1;
            job_o.status     = StDistOk;
            job_o.dist_ok    = (edly_q > zdly_q) && (msw_q != '0);
            job_o.inch       = unit_sel_i;
            job_o.delta      = delta_w;
            job_o.divisor    = msw_w;
            job_o.echo_width = pulse_w[FieldW-1:0];
            job_o.echo_peak  = peak_q;
          end
        end
        default: tick_d = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhCalHigh;
      tick_q  <= '0;
      msw_q   <= '0;
      zdly_q  <= '0;
      edly_q  <= '0;
      peak_q  <= '0;
      pulse_q <= '0;
    end else begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      msw_q   <= msw_d;
      zdly_q  <= zdly_d;
      edly_q  <= edly_d;
      peak_q  <= peak_d;
      pulse_q <= pulse_d;
    end
  end

endmodule

// ===== hw/rtl/lrt_fifo.sv =====
module lrt_fifo
  import lrt_pkg::*;
#(
  parameter int unsigned DEPTH = FifoDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  job_t       data_i,
  input  logic       pop_i,
  output job_t       data_o,
  output fifo_stat_t stat_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  job_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign stat_o.full  = cnt_q == CntFull;
  assign stat_o.empty = cnt_q == '0;
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign data_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
    if (do_pop) rd_d = (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (do_pop && !do_push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

endmodule

// ===== hw/rtl/lrt_back.sv =====
module lrt_back
  import lrt_pkg::*;
#(
  parameter int unsigned TIME_BITS = TimeBitsDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    job_avail_i,
  input  job_t    job_i,
  output logic    pop_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t out_o
);

  localparam int unsigned PW   = TIME_BITS + KW;
  localparam int unsigned CntW = $clog2(DistW);

  back_e                st_q, st_d;
  job_t                 job_q, job_d;
  logic [PW-1:0]        prod_q, prod_d;
  logic [PW-1:0]        rem_q, rem_d;
  logic [PW-1:0]        dsh_q, dsh_d;
  logic [DistW-1:0]     quo_q, quo_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  result_t              out_q, out_d;
  logic                 out_valid_q, out_valid_d;

  logic [TIME_BITS-1:0] divisor, delta;
  logic [KW-1:0]        kfac;
  logic                 over, ge, out_free, start_div;

  assign divisor   = job_q.divisor[TIME_BITS-1:0];
  assign delta     = job_q.delta[TIME_BITS-1:0];
  assign kfac      = job_q.inch ? KIn : KCm;
  assign over      = {1'b0, prod_q} >= {divisor, DistW'(0)};
  assign ge        = rem_q >= dsh_q;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign start_div = (job_i.status == StDistOk) && job_i.dist_ok;

  assign pop_o       = (st_q == BkIdle) && job_avail_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    st_d = st_q;
    case (st_q)
      BkIdle: if (job_avail_i) st_d = start_div ? BkMul : BkOut;
      BkMul:  st_d = BkChk;
      BkChk:  st_d = over ? BkOut : BkDiv;
      BkDiv:  if (cnt_q == '0) st_d = BkOut;
      BkOut:  if (out_free) st_d = BkIdle;
      default: st_d = BkIdle;
    endcase
  end

  always_comb begin
    job_d       = job_q;
    prod_d      = prod_q;
    rem_d       = rem_q;
    dsh_d       = dsh_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (st_q)
      BkIdle: begin
        job_d = job_i;
        quo_d = '0;
      end
      BkMul: prod_d = PW'(delta) * PW'(kfac);
      BkChk: begin
        if (over) begin
          quo_d = DistMax;
        end else begin
          // quotient fits in the distance width: restoring divide, MSB first
          rem_d = prod_q;
          dsh_d = {divisor, (DistW - 1)'(0)};
          cnt_d = CntW'(DistW - 1);
          quo_d = '0;
        end
      end
      BkDiv: begin
        rem_d = ge ? rem_q - dsh_q : rem_q;
        quo_d = {quo_q[DistW-2:0], ge};
        dsh_d = dsh_q >> 1;
        cnt_d = cnt_q - 1'b1;
      end
      BkOut: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.status      = job_q.status;
          out_d.distance    = quo_q;
          out_d.echo_width  = job_q.echo_width;
          out_d.echo_peak   = job_q.echo_peak;
          out_d.sync_period = job_q.sync_period;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= BkIdle;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    prod_q <= prod_d;
    rem_q  <= rem_d;
    dsh_q  <= dsh_d;
    quo_q  <= quo_d;
    cnt_q  <= cnt_d;
    out_q  <= out_d;
  end

endmodule

// ===== hw/rtl/laser_rangefinder_echo_timer.sv =====
// Laser rangefinder echo timer.
// Input channel (in_valid_i / in_stall_o / in_i): one request per microsecond
// tick with the sync pin level and the echo and zero converter samples.
// Output channel (out_valid_o / out_stall_i / out_o): at most one result per
// tick: distance, no echo, sync timeout or calibration done.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i; write
// only while the block is idle.
// Throughput: one tick per cycle while the 4-entry queue between the timing
// front end and the distance back end has room; in_stall_o is high while it
// is full. The back end works out each distance with its 12-step restoring
// divider and takes no new job until the result is in the output register.
// A distance passes the multiply, range check, divide and output states; a
// saturated one skips the divide, a status result goes straight to output.
// Reset: thresholds, timeout and unit go to their defaults and calibration
// starts over; the queue and output register empty.
// A stalled result holds in the output register; ticks keep flowing until
// the queue fills.
module laser_rangefinder_echo_timer
  import lrt_pkg::*;
#(
  parameter int unsigned TIME_BITS  = TimeBitsDef,
  parameter int unsigned FIFO_DEPTH = FifoDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tick_t             in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output result_t           out_o,
  input  logic              cfg_we_i,
  input  cfg_idx_e          cfg_idx_i,
  input  logic [FieldW-1:0] cfg_wdata_i
);

  logic [SampleW-1:0] echo_thr_q, zero_thr_q;
  logic [FieldW-1:0]  sync_timeout_q;
  logic               unit_sel_q;

  logic       step, push, pop;
  job_t       push_job, pop_job;
  fifo_stat_t fifo_stat;

  assign in_stall_o = fifo_stat.full;
  assign step       = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      echo_thr_q     <= EchoThrRst;
      zero_thr_q     <= ZeroThrRst;
      sync_timeout_q <= SyncTimeoutRst;
      unit_sel_q     <= UnitSelRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgEchoThr:     echo_thr_q     <= cfg_wdata_i[SampleW-1:0];
        CfgZeroThr:     zero_thr_q     <= cfg_wdata_i[SampleW-1:0];
        CfgSyncTimeout: sync_timeout_q <= cfg_wdata_i;
        CfgUnitSel:     unit_sel_q     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  lrt_front #(
    .TIME_BITS (TIME_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .tick_i         (in_i),
    .echo_thr_i     (echo_thr_q),
    .zero_thr_i     (zero_thr_q),
    .sync_timeout_i (sync_timeout_q),
    .unit_sel_i     (unit_sel_q),
    .push_o         (push),
    .job_o          (push_job)
  );

  lrt_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_job),
    .pop_i  (pop),
    .data_o (pop_job),
    .stat_o (fifo_stat)
  );

  lrt_back #(
    .TIME_BITS (TIME_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_avail_i (!fifo_stat.empty),
    .job_i       (pop_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

`ifndef NO_ASSERTIONS
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !fifo_stat.full)
    else $error("measurement pushed into a full queue");

  a_pop_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !fifo_stat.empty)
    else $error("back end popped an empty queue");

  a_status_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.status != StDistOk) |->
      (out_o.distance == '0) && (out_o.echo_width == '0) && (out_o.echo_peak == '0))
    else $error("status result carries measurement fields");
`endif

endmodule
